### design/eiot_pkg.sv
// Package for the exclusive input ownership table.
// Holds sizes, field widths, operation and state codes, and the shared item types.
// No dependencies.
`default_nettype none

package eiot_pkg;

    localparam int TRACKS = 16;
    localparam int INPUTS = 8;

    localparam int FUNC_W = 2;
    localparam int TRK_W  = 4;
    localparam int INP_W  = 3;
    localparam int TIME_W = 64;
    localparam int MASK_W = 16;

    localparam int TCNT_W = (TRACKS > 1) ? $clog2(TRACKS) : 1;
    localparam int ICNT_W = (INPUTS > 1) ? $clog2(INPUTS) : 1;

    localparam int QDEPTH = 2;

    localparam logic [FUNC_W-1:0] FUNC_ASSIGN  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_REAPPLY = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_QUERY   = 2'd2;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_CMD    = 1'b1;

    typedef enum logic [1:0] {
        OP_ASSIGN,
        OP_REAPPLY,
        OP_QUERY,
        OP_REJECT
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_QUERY,
        S_BUILD,
        S_DIFF,
        S_STATUS
    } state_t;

    // Classified item handed from the front to the back.
    typedef struct packed {
        op_t               op;
        logic [TRK_W-1:0]  track_index;
        logic [INP_W-1:0]  input_index;
        logic [TIME_W-1:0] stamp;
    } op_item_t;

    typedef struct packed {
        logic              kind;
        logic              accepted;
        logic [INP_W-1:0]  changed_input;
        logic [TRK_W-1:0]  owner_track;
        logic              has_owner;
        logic              may_claim;
        logic              is_owner;
        logic [INP_W-1:0]  track_selection;
        logic [TIME_W-1:0] stamp_time;
        logic              last;
    } res_t;

endpackage

`default_nettype wire

### design/eiot_ifs.sv
// Channel interfaces of the exclusive input ownership table: command, result, config.
// Depends on eiot_pkg for field widths.
`default_nettype none

interface eiot_cmd_if;
    logic                        valid;
    logic                        ready;
    logic [eiot_pkg::FUNC_W-1:0] func;
    logic [eiot_pkg::TRK_W-1:0]  track_index;
    logic [eiot_pkg::INP_W-1:0]  input_index;
    logic [eiot_pkg::TIME_W-1:0] stamp;

    modport source (output valid, func, track_index, input_index, stamp,
                    input ready);
    modport sink (input valid, func, track_index, input_index, stamp,
                  output ready);
endinterface

interface eiot_res_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic                        accepted;
    logic [eiot_pkg::INP_W-1:0]  changed_input;
    logic [eiot_pkg::TRK_W-1:0]  owner_track;
    logic                        has_owner;
    logic                        may_claim;
    logic                        is_owner;
    logic [eiot_pkg::INP_W-1:0]  track_selection;
    logic [eiot_pkg::TIME_W-1:0] stamp_time;
    logic                        last;

    modport source (output valid, kind, accepted, changed_input, owner_track, has_owner,
                    may_claim, is_owner, track_selection, stamp_time, last,
                    input ready);
    modport sink (input valid, kind, accepted, changed_input, owner_track, has_owner,
                  may_claim, is_owner, track_selection, stamp_time, last,
                  output ready);
endinterface

interface eiot_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [eiot_pkg::MASK_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

### design/eiot_front.sv
// Front end: accepts command items, classifies them and holds them in a two-entry queue.
// Depends on eiot_pkg and eiot_cmd_if.
`default_nettype none

module eiot_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    eiot_cmd_if.sink                cmd,
    output eiot_pkg::op_item_t      q_head,
    output logic                    q_valid,
    input  wire logic               q_pop
);
    import eiot_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    op_item_t           q_reg [QDEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               push;
    logic               in_range;
    op_item_t           cls;

    assign cmd.ready = (cnt_reg != CNT_W'(QDEPTH));
    assign push      = cmd.valid && cmd.ready;
    assign q_valid   = (cnt_reg != '0);
    assign q_head    = q_reg[rd_ptr_reg];

    assign in_range = (32'(cmd.track_index) < TRACKS) && (32'(cmd.input_index) < INPUTS);

    always_comb
    begin
        cls.track_index = cmd.track_index;
        cls.input_index = cmd.input_index;
        cls.stamp       = cmd.stamp;
        unique case (cmd.func)
            FUNC_ASSIGN:  cls.op = in_range ? OP_ASSIGN : OP_REJECT;
            FUNC_REAPPLY: cls.op = OP_REAPPLY;
            FUNC_QUERY:   cls.op = in_range ? OP_QUERY : OP_REJECT;
            default:      cls.op = OP_REJECT;
        endcase
    end

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == QDEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == QDEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !(q_pop && q_valid))
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!push && q_pop && q_valid)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

### design/eiot_back.sv
// Back end: holds selections, owner map and mask; walks tracks to rebuild the owner map,
// walks inputs to emit ownership commands, and drives the registered result channel.
// Depends on eiot_pkg, eiot_res_if and eiot_cfg_if.
`default_nettype none

module eiot_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  eiot_pkg::op_item_t      q_head,
    input  wire logic               q_valid,
    output logic                    q_pop,
    eiot_cfg_if.sink                cfg,
    eiot_res_if.source              res
);
    import eiot_pkg::*;

    state_t              state_reg, state_next;
    op_item_t            op_reg, op_next;
    logic [TCNT_W-1:0]   trk_ctr_reg, trk_ctr_next;
    logic [ICNT_W-1:0]   inp_ctr_reg, inp_ctr_next;
    logic                ok_reg, ok_next;
    logic [MASK_W-1:0]   mask_reg;
    res_t                res_reg, res_next;
    logic                res_valid_reg, res_valid_next;

    logic [INP_W-1:0]    sel_reg [TRACKS];
    logic [TRK_W-1:0]    own_reg [INPUTS];
    logic                pres_reg [INPUTS];
    logic [TRK_W-1:0]    new_own_reg [INPUTS];
    logic                new_pres_reg [INPUTS];

    logic                can_emit;
    logic                clear_new;
    logic                build_wr;
    logic                commit;
    logic [TRACKS-1:0]   ext_vec;
    logic [TCNT_W-1:0]   sel_addr;
    logic [INP_W-1:0]    sel_rd;
    logic [INP_W-1:0]    sel_at_t;
    logic [ICNT_W-1:0]   new_addr;
    logic [ICNT_W-1:0]   old_addr;
    logic                new_pres_rd;
    logic [TRK_W-1:0]    new_own_rd;
    logic                pres_rd;
    logic [TRK_W-1:0]    own_rd;
    logic                is_ext;
    logic                bad;
    logic                diff;
    logic [TRK_W-1:0]    q_owner;

    assign cfg.ready = 1'b1;

    // Tracks past the mask width are never external.
    assign ext_vec  = TRACKS'(mask_reg);
    assign can_emit = !res_valid_reg || res.ready;

    // One read port per table; the address follows the phase.
    assign sel_addr = (state_reg == S_BUILD) ? trk_ctr_reg
                                             : op_reg.track_index[TCNT_W-1:0];
    assign sel_rd   = sel_reg[sel_addr];
    assign sel_at_t = (op_reg.op == OP_ASSIGN &&
                       trk_ctr_reg == op_reg.track_index[TCNT_W-1:0])
                      ? op_reg.input_index : sel_rd;

    assign new_addr    = (state_reg == S_BUILD) ? sel_at_t[ICNT_W-1:0] : inp_ctr_reg;
    assign new_pres_rd = new_pres_reg[new_addr];
    assign new_own_rd  = new_own_reg[new_addr];

    assign old_addr = (state_reg == S_DIFF) ? inp_ctr_reg
                                            : op_reg.input_index[ICNT_W-1:0];
    assign pres_rd  = pres_reg[old_addr];
    assign own_rd   = own_reg[old_addr];
    assign q_owner  = pres_rd ? own_rd : '0;

    assign is_ext = ext_vec[trk_ctr_reg];
    assign bad    = (32'(sel_at_t) >= INPUTS) || (is_ext && new_pres_rd);
    assign diff   = (new_pres_rd != pres_rd) || (new_pres_rd && new_own_rd != own_rd);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        trk_ctr_next   = trk_ctr_reg;
        inp_ctr_next   = inp_ctr_reg;
        ok_next        = ok_reg;
        res_next       = res_reg;
        res_valid_next = res_valid_reg && !res.ready;
        q_pop          = 1'b0;
        clear_new      = 1'b0;
        build_wr       = 1'b0;
        commit         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop        = 1'b1;
                    op_next      = q_head;
                    trk_ctr_next = '0;
                    inp_ctr_next = '0;
                    ok_next      = 1'b1;
                    clear_new    = 1'b1;
                    unique case (q_head.op)
                        OP_ASSIGN, OP_REAPPLY: state_next = S_BUILD;
                        OP_QUERY, OP_REJECT:   state_next = S_QUERY;
                    endcase
                end
            end

            S_QUERY:
            begin
                if (can_emit)
                begin
                    res_valid_next = 1'b1;
                    res_next       = '0;
                    res_next.kind  = KIND_STATUS;
                    res_next.last  = 1'b1;
                    if (op_reg.op == OP_QUERY)
                    begin
                        res_next.accepted        = 1'b1;
                        res_next.changed_input   = op_reg.input_index;
                        res_next.owner_track     = q_owner;
                        res_next.has_owner       = pres_rd;
                        res_next.may_claim       = !pres_rd || (q_owner == op_reg.track_index);
                        res_next.is_owner        = pres_rd && (q_owner == op_reg.track_index);
                        res_next.track_selection = sel_rd;
                    end
                    state_next = S_IDLE;
                end
            end

            S_BUILD:
            begin
                if (bad)
                begin
                    // Conflict or bad selection: drop the whole change.
                    ok_next    = 1'b0;
                    state_next = S_STATUS;
                end
                else
                begin
                    build_wr = is_ext;
                    if (32'(trk_ctr_reg) == TRACKS - 1)
                    begin
                        state_next = S_DIFF;
                    end
                    else
                    begin
                        trk_ctr_next = trk_ctr_reg + 1'b1;
                    end
                end
            end

            S_DIFF:
            begin
                if (!diff || can_emit)
                begin
                    if (diff)
                    begin
                        res_valid_next         = 1'b1;
                        res_next               = '0;
                        res_next.kind          = KIND_CMD;
                        res_next.accepted      = 1'b1;
                        res_next.changed_input = INP_W'(inp_ctr_reg);
                        res_next.owner_track   = new_own_rd;
                        res_next.has_owner     = new_pres_rd;
                        res_next.stamp_time    = op_reg.stamp;
                    end
                    if (32'(inp_ctr_reg) == INPUTS - 1)
                    begin
                        state_next = S_STATUS;
                    end
                    else
                    begin
                        inp_ctr_next = inp_ctr_reg + 1'b1;
                    end
                end
            end

            S_STATUS:
            begin
                if (can_emit)
                begin
                    res_valid_next    = 1'b1;
                    res_next          = '0;
                    res_next.kind     = KIND_STATUS;
                    res_next.accepted = ok_reg;
                    res_next.last     = 1'b1;
                    commit            = ok_reg;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            res_valid_reg <= 1'b0;
            mask_reg      <= '0;
            trk_ctr_reg   <= '0;
            inp_ctr_reg   <= '0;
            ok_reg        <= 1'b1;
            for (int t = 0; t < TRACKS; t++)
            begin
                sel_reg[t] <= INP_W'(t % INPUTS);
            end
            for (int i = 0; i < INPUTS; i++)
            begin
                own_reg[i]  <= '0;
                pres_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
            trk_ctr_reg   <= trk_ctr_next;
            inp_ctr_reg   <= inp_ctr_next;
            ok_reg        <= ok_next;
            if (cfg.valid)
            begin
                mask_reg <= cfg.data;
            end
            if (commit)
            begin
                if (op_reg.op == OP_ASSIGN)
                begin
                    sel_reg[op_reg.track_index[TCNT_W-1:0]] <= op_reg.input_index;
                end
                for (int i = 0; i < INPUTS; i++)
                begin
                    own_reg[i]  <= new_own_reg[i];
                    pres_reg[i] <= new_pres_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg  <= op_next;
        res_reg <= res_next;
        if (clear_new)
        begin
            for (int i = 0; i < INPUTS; i++)
            begin
                new_own_reg[i]  <= '0;
                new_pres_reg[i] <= 1'b0;
            end
        end
        else if (build_wr)
        begin
            new_own_reg[new_addr]  <= TRK_W'(trk_ctr_reg);
            new_pres_reg[new_addr] <= 1'b1;
        end
    end

    assign res.valid           = res_valid_reg;
    assign res.kind            = res_reg.kind;
    assign res.accepted        = res_reg.accepted;
    assign res.changed_input   = res_reg.changed_input;
    assign res.owner_track     = res_reg.owner_track;
    assign res.has_owner       = res_reg.has_owner;
    assign res.may_claim       = res_reg.may_claim;
    assign res.is_owner        = res_reg.is_owner;
    assign res.track_selection = res_reg.track_selection;
    assign res.stamp_time      = res_reg.stamp_time;
    assign res.last            = res_reg.last;

endmodule

`default_nettype wire

### design/exclusive_input_ownership_table_unit.sv
// Top level of the exclusive input ownership table.
// Depends on eiot_pkg, the channel interfaces, eiot_front and eiot_back.
`default_nettype none

// Each of 16 tracks selects one of 8 inputs; tracks set in the external mask must own
// distinct inputs. An assign or reapply walks the tracks, one per cycle, to rebuild the
// owner map, then walks the inputs, one per cycle, to compare it with the current map,
// set by the single read port on the selection and owner tables; a stalled result side
// holds back a command or the status item, and the input walk waits on a held command. A
// rejected change ends as soon as the track walk finds the conflict. A query or a rejected
// item goes straight to its single status item. A two-item queue takes new items while the
// back end works. Write the mask only while idle.
module exclusive_input_ownership_table_unit (
    input  wire logic clk,
    input  wire logic rst_n,
    eiot_cmd_if.sink  cmd,
    eiot_cfg_if.sink  cfg,
    eiot_res_if.source res
);
    import eiot_pkg::*;

    op_item_t q_head;
    logic     q_valid;
    logic     q_pop;

    eiot_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop)
    );

    eiot_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_head  (q_head),
        .q_valid (q_valid),
        .q_pop   (q_pop),
        .cfg     (cfg),
        .res     (res)
    );

endmodule

`default_nettype wire

### design/eiot_checker.sv
// Port-level checks on the result channel of the ownership table, and their bind.
// Depends on eiot_pkg, exclusive_input_ownership_table_unit and the channel interfaces.
`default_nettype none

module eiot_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        res_valid,
    input wire logic        res_ready,
    input wire logic        res_kind,
    input wire logic        res_accepted,
    input wire logic        res_last,
    input wire logic [3:0]  res_owner_track,
    input wire logic        res_has_owner,
    input wire logic [63:0] res_stamp_time
);
    import eiot_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid)
        else $error("result valid dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> $stable(res_kind) && $stable(res_last)
                                    && $stable(res_owner_track))
        else $error("result item changed while stalled");

    a_cmd_shape: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_CMD |-> res_accepted && !res_last)
        else $error("command item must be accepted and not last");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_kind == KIND_STATUS && !res_accepted |->
            res_last && !res_has_owner && res_owner_track == '0 && res_stamp_time == '0)
        else $error("rejected status item carries data");

endmodule

bind exclusive_input_ownership_table_unit eiot_checker u_eiot_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .res_valid       (res.valid),
    .res_ready       (res.ready),
    .res_kind        (res.kind),
    .res_accepted    (res.accepted),
    .res_last        (res.last),
    .res_owner_track (res.owner_track),
    .res_has_owner   (res.has_owner),
    .res_stamp_time  (res.stamp_time)
);

`default_nettype wire
